// ===== design/grid_rotate_and_diagonal_skew_macros.svh =====
// assertion macros for the grid rotate and skew block
// used by the port checker; no other dependencies
`ifndef GRID_ROTATE_AND_DIAGONAL_SKEW_MACROS_SVH
`define GRID_ROTATE_AND_DIAGONAL_SKEW_MACROS_SVH

// same-cycle implication, skipped while rst is high
`define GRS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid rotate check failed");

// next-cycle implication, skipped while rst is high
`define GRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grid rotate check failed");

`endif

// ===== design/grs_pkg.sv =====
// shared types and codes for the grid rotate and skew block
// no dependencies
`default_nettype none

package grs_pkg;

   // default grid limits
   localparam int MAX_ROWS_DEF = 64;
   localparam int MAX_COLS_DEF = 64;

   // padding character
   localparam logic [7:0] SPACE_CHAR = 8'h20;

   // request modes
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_FETCH = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // orientation codes, the unused code behaves as the turn
   localparam logic [1:0] ORI_TURN   = 2'd0;
   localparam logic [1:0] ORI_SKEW_R = 2'd1;
   localparam logic [1:0] ORI_SKEW_L = 2'd2;

   // one response item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       row_last;
      logic       grid_last;
      logic       exhausted;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/grid_rotate_and_diagonal_skew.sv =====
// Grid rotate and diagonal skew, top level.
// A byte grid is loaded row by row on the request channel (mode load, with
// row_end on the last byte of each row; the first row sets the width), and
// each fetch request returns one response with the next byte of the grid
// reoriented: turned clockwise, anti-diagonals skewed right, or diagonals
// skewed left with trailing spaces trimmed, as csr_wr_data selects.
// Loads, clears and mode-3 requests give no response; a load that ends a
// short row then pads the missing columns with spaces while the request
// channel is held. A fetch holds the request channel while it steps the
// addresses and waits on the one read port of the grid store; at the start
// of a left-skew row it also scans the diagonal, one setup step and then a
// read and a check per byte examined. Requests are handled one at a time.
// The response register decouples the channels: a new request is taken
// while a response waits, but a fetch that finishes while rsp_ready is low
// holds there until the waiting response is taken.
// Reset empties the grid, sets the turn orientation and drops rsp_valid.
// Grid bytes are not cleared; only written bytes are ever read.
// depends on grs_pkg, grs_ctrl and grs_store
`default_nettype none

module grid_rotate_and_diagonal_skew import grs_pkg::*; #(
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_mode,
   input  wire logic [7:0] req_grid_byte,
   input  wire logic       req_row_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic      [7:0] rsp_out_byte,
   output logic            rsp_has_byte,
   output logic            rsp_row_last,
   output logic            rsp_grid_last,
   output logic            rsp_exhausted,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_wr_data
);

   localparam int ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ADDR_W    = ROW_IDX_W + COL_IDX_W;

   logic [1:0]        orientation_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   logic              rsp_free;
   logic              emit_valid;
   rsp_type           emit_res;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;

   // orientation register
   always_ff @(posedge clock) begin
      if (reset) begin
         orientation_ff <= ORI_TURN;
      end else if (csr_wr_en) begin
         orientation_ff <= csr_wr_data;
      end
   end

   // response register
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_valid && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit_valid && rsp_free) begin
         rsp_ff <= emit_res;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_ff.out_byte;
   assign rsp_has_byte  = rsp_ff.has_byte;
   assign rsp_row_last  = rsp_ff.row_last;
   assign rsp_grid_last = rsp_ff.grid_last;
   assign rsp_exhausted = rsp_ff.exhausted;

   // sequencer
   grs_ctrl #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_grid_byte (req_grid_byte),
      .req_row_end   (req_row_end),
      .orientation   (orientation_ff),
      .restart       (csr_wr_en),
      .rsp_free      (rsp_free),
      .emit_valid    (emit_valid),
      .emit_res      (emit_res),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data)
   );

   // grid store
   grs_store #(
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

// ===== design/grs_store.sv =====
// grid byte store: one write port, one registered read port
// depends on nothing but its address width
`default_nettype none

module grs_store #(
   parameter int ADDR_W = 12
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   logic [7:0] mem [2**ADDR_W];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== design/grs_ctrl.sv =====
// sequencer: grid loading, cursor and per-fetch address stepping
// depends on grs_pkg; drives the ports of grs_store
`default_nettype none

module grs_ctrl import grs_pkg::*; #(
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int MAX_COLS = MAX_COLS_DEF,
   localparam int ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   localparam int COL_IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
   localparam int ADDR_W    = ROW_IDX_W + COL_IDX_W
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_mode,
   input  wire logic [7:0]        req_grid_byte,
   input  wire logic              req_row_end,
   input  wire logic [1:0]        orientation,
   input  wire logic              restart,
   input  wire logic              rsp_free,
   output logic                   emit_valid,
   output rsp_type                emit_res,
   output logic                   wr_en,
   output logic      [ADDR_W-1:0] wr_addr,
   output logic      [7:0]        wr_data,
   output logic                   rd_en,
   output logic      [ADDR_W-1:0] rd_addr,
   input  wire logic [7:0]        rd_data
);

   localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
   localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
   localparam int POS_W     = $clog2(MAX_ROWS + MAX_COLS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_FILL, S_PLAN, S_SKEW, S_SKEW2, S_READ, S_DATA,
      S_SCAN_INIT, S_SCAN_RD, S_SCAN_CHK, S_LEFT, S_FIN
   } state_type;

   state_type              state_ff, state_in;
   logic [ROW_CNT_W-1:0]   rows_ff, rows_in;
   logic [COL_CNT_W-1:0]   cols_ff, cols_in;
   logic [COL_CNT_W-1:0]   load_col_ff, load_col_in;
   logic [ROW_IDX_W-1:0]   fill_row_ff, fill_row_in;
   logic [COL_CNT_W-1:0]   fill_col_ff, fill_col_in;
   logic [POS_W-1:0]       out_row_ff, out_row_in;
   logic [POS_W-1:0]       out_col_ff, out_col_in;
   logic [POS_W-1:0]       trim_ff, trim_in;
   logic [POS_W-1:0]       len_ff, len_in;
   logic [POS_W-1:0]       lo_ff, lo_in;
   logic [POS_W-1:0]       span_ff, span_in;
   logic [POS_W-1:0]       rd_row_ff, rd_row_in;
   logic [POS_W-1:0]       rd_col_ff, rd_col_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   has_ff, has_in;
   logic                   exh_ff, exh_in;

   logic                   accept;
   logic                   is_skew;
   logic [POS_W-1:0]       rows_x, cols_x;
   logic [POS_W-1:0]       nrows_w, lo_w, hi_w, base_w, span_w;
   logic [POS_W-1:0]       edge1_w, edge2_w, min1_w, min2_w;
   logic                   row_last_w, grid_last_w;
   logic [COL_CNT_W-1:0]   lc_next, load_limit;
   logic                   row_room;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   // grid extent and per-row geometry from the cursor
   assign rows_x  = POS_W'(rows_ff);
   assign cols_x  = POS_W'(cols_ff);
   assign is_skew = (orientation == ORI_SKEW_R) || (orientation == ORI_SKEW_L);

   always_comb begin
      if (rows_ff == '0 || cols_ff == '0) begin
         nrows_w = '0;
      end else if (is_skew) begin
         nrows_w = rows_x + cols_x - POS_W'(1);
      end else begin
         nrows_w = cols_x;
      end
   end

   assign lo_w   = (out_row_ff >= rows_x) ? out_row_ff + POS_W'(1) - rows_x : '0;
   assign hi_w   = (out_row_ff < cols_x - POS_W'(1)) ? out_row_ff : cols_x - POS_W'(1);
   assign base_w = (out_row_ff >= cols_x) ? out_row_ff + POS_W'(1) - cols_x : '0;

   // anti-diagonal length: min of four bounds
   assign edge1_w = out_row_ff + POS_W'(1);
   assign edge2_w = nrows_w - out_row_ff;
   assign min1_w  = (edge1_w < edge2_w) ? edge1_w : edge2_w;
   assign min2_w  = (cols_x < rows_x) ? cols_x : rows_x;
   assign span_w  = (min1_w < min2_w) ? min1_w : min2_w;

   assign row_last_w  = (out_col_ff + POS_W'(1) >= len_ff);
   assign grid_last_w = row_last_w && (out_row_ff + POS_W'(1) == nrows_w);

   // load bookkeeping
   assign row_room   = (rows_ff < ROW_CNT_W'(MAX_ROWS));
   assign load_limit = (rows_ff == '0) ? COL_CNT_W'(MAX_COLS) : cols_ff;
   assign lc_next    = (load_col_ff < COL_CNT_W'(MAX_COLS)) ? load_col_ff + COL_CNT_W'(1)
                                                            : load_col_ff;

   // store ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {rows_ff[ROW_IDX_W-1:0], load_col_ff[COL_IDX_W-1:0]};
      wr_data = req_grid_byte;
      if (state_ff == S_FILL) begin
         wr_en   = 1'b1;
         wr_addr = {fill_row_ff, fill_col_ff[COL_IDX_W-1:0]};
         wr_data = SPACE_CHAR;
      end else if (accept && req_mode == MODE_LOAD && row_room &&
                   load_col_ff < load_limit) begin
         wr_en = 1'b1;
      end
   end

   assign rd_en   = (state_ff == S_READ) || (state_ff == S_SCAN_RD);
   assign rd_addr = {rd_row_ff[ROW_IDX_W-1:0], rd_col_ff[COL_IDX_W-1:0]};

   // response assembly
   assign emit_valid         = (state_ff == S_FIN);
   assign emit_res.out_byte  = byte_ff;
   assign emit_res.has_byte  = has_ff;
   assign emit_res.row_last  = !exh_ff && row_last_w;
   assign emit_res.grid_last = !exh_ff && grid_last_w;
   assign emit_res.exhausted = exh_ff;

   // next-state logic
   always_comb begin
      state_in    = state_ff;
      rows_in     = rows_ff;
      cols_in     = cols_ff;
      load_col_in = load_col_ff;
      fill_row_in = fill_row_ff;
      fill_col_in = fill_col_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      trim_in     = trim_ff;
      len_in      = len_ff;
      lo_in       = lo_ff;
      span_in     = span_ff;
      rd_row_in   = rd_row_ff;
      rd_col_in   = rd_col_ff;
      byte_in     = byte_ff;
      has_in      = has_ff;
      exh_in      = exh_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority case (req_mode)
                  MODE_LOAD: begin
                     out_row_in = '0;
                     out_col_in = '0;
                     trim_in    = '0;
                     if (row_room) begin
                        load_col_in = lc_next;
                        if (req_row_end) begin
                           rows_in     = rows_ff + ROW_CNT_W'(1);
                           load_col_in = '0;
                           if (rows_ff == '0) begin
                              cols_in = lc_next;
                           end else if (lc_next < cols_ff) begin
                              // short row: pad the missing columns
                              fill_row_in = rows_ff[ROW_IDX_W-1:0];
                              fill_col_in = lc_next;
                              state_in    = S_FILL;
                           end
                        end
                     end
                  end
                  MODE_FETCH: begin
                     state_in = S_PLAN;
                  end
                  MODE_CLEAR: begin
                     rows_in     = '0;
                     cols_in     = '0;
                     load_col_in = '0;
                     out_row_in  = '0;
                     out_col_in  = '0;
                     trim_in     = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_FILL: begin
            if (fill_col_ff + COL_CNT_W'(1) >= cols_ff) begin
               state_in = S_IDLE;
            end else begin
               fill_col_in = fill_col_ff + COL_CNT_W'(1);
            end
         end

         S_PLAN: begin
            has_in = 1'b1;
            exh_in = 1'b0;
            if (out_row_ff >= nrows_w) begin
               // nothing left to emit
               exh_in   = 1'b1;
               has_in   = 1'b0;
               byte_in  = '0;
               state_in = S_FIN;
            end else begin
               unique case (orientation)
                  ORI_SKEW_R: begin
                     span_in  = span_w;
                     state_in = S_SKEW;
                  end
                  ORI_SKEW_L: begin
                     lo_in = lo_w;
                     if (out_col_ff == '0) begin
                        rd_col_in = hi_w;
                        state_in  = S_SCAN_INIT;
                     end else begin
                        state_in = S_LEFT;
                     end
                  end
                  default: begin
                     rd_row_in = rows_x - POS_W'(1) - out_col_ff;
                     rd_col_in = out_row_ff;
                     len_in    = rows_x;
                     state_in  = S_READ;
                  end
               endcase
            end
         end

         // right skew: leading spaces, then the anti-diagonal
         S_SKEW: begin
            len_in = span_ff << 1;
            if (out_col_ff < span_ff) begin
               byte_in  = SPACE_CHAR;
               state_in = S_FIN;
            end else begin
               rd_row_in = base_w + out_col_ff - span_ff;
               state_in  = S_SKEW2;
            end
         end

         S_SKEW2: begin
            rd_col_in = out_row_ff - rd_row_ff;
            state_in  = S_READ;
         end

         S_READ: begin
            state_in = S_DATA;
         end

         S_DATA: begin
            byte_in  = rd_data;
            state_in = S_FIN;
         end

         // left skew: scan the diagonal back from its last byte for the trimmed length
         S_SCAN_INIT: begin
            rd_row_in = rows_x + rd_col_ff - out_row_ff - POS_W'(1);
            state_in  = S_SCAN_RD;
         end

         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end

         S_SCAN_CHK: begin
            if (rd_data != SPACE_CHAR) begin
               trim_in  = rd_col_ff + POS_W'(1);
               state_in = S_LEFT;
            end else if (rd_col_ff == lo_ff) begin
               trim_in  = '0;
               state_in = S_LEFT;
            end else begin
               rd_col_in = rd_col_ff - POS_W'(1);
               rd_row_in = rd_row_ff - POS_W'(1);
               state_in  = S_SCAN_RD;
            end
         end

         S_LEFT: begin
            if (trim_ff == '0) begin
               // empty row after trimming
               byte_in  = '0;
               has_in   = 1'b0;
               len_in   = POS_W'(1);
               state_in = S_FIN;
            end else begin
               len_in = trim_ff;
               if (out_col_ff < lo_ff) begin
                  byte_in  = SPACE_CHAR;
                  state_in = S_FIN;
               end else begin
                  rd_col_in = out_col_ff;
                  rd_row_in = rows_x + out_col_ff - out_row_ff - POS_W'(1);
                  state_in  = S_READ;
               end
            end
         end

         S_FIN: begin
            if (rsp_free) begin
               state_in = S_IDLE;
               if (!exh_ff) begin
                  if (row_last_w) begin
                     out_row_in = out_row_ff + POS_W'(1);
                     out_col_in = '0;
                  end else begin
                     out_col_in = out_col_ff + POS_W'(1);
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register write restarts the output
      if (restart) begin
         out_row_in = '0;
         out_col_in = '0;
         trim_in    = '0;
      end
   end

   // state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rows_ff     <= '0;
         cols_ff     <= '0;
         load_col_ff <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         trim_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         rows_ff     <= rows_in;
         cols_ff     <= cols_in;
         load_col_ff <= load_col_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
         trim_ff     <= trim_in;
      end
      fill_row_ff <= fill_row_in;
      fill_col_ff <= fill_col_in;
      len_ff      <= len_in;
      lo_ff       <= lo_in;
      span_ff     <= span_in;
      rd_row_ff   <= rd_row_in;
      rd_col_ff   <= rd_col_in;
      byte_ff     <= byte_in;
      has_ff      <= has_in;
      exh_ff      <= exh_in;
   end

endmodule

`default_nettype wire

// ===== design/grs_checker.sv =====
// port-level checks for the grid rotate and skew block, bound to the top
// depends on grs_pkg and grid_rotate_and_diagonal_skew_macros.svh
`default_nettype none
`include "grid_rotate_and_diagonal_skew_macros.svh"

module grs_checker import grs_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_mode,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_has_byte,
   input wire logic       rsp_row_last,
   input wire logic       rsp_grid_last,
   input wire logic       rsp_exhausted
);

   // a stalled response holds
   `GRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_out_byte, rsp_has_byte, rsp_row_last, rsp_grid_last, rsp_exhausted}))

   // reset drops the response channel
   `GRS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

   // a fetch keeps the request channel busy for its work
   `GRS_ASSERT_NEXT(a_fetch_busy, clock, reset, req_valid && req_ready && req_mode == MODE_FETCH, !req_ready)

   // an exhausted response carries nothing else
   `GRS_ASSERT_IMPLY(a_exh_clean, clock, reset, rsp_valid && rsp_exhausted, rsp_out_byte == 8'h00 && !rsp_has_byte && !rsp_row_last && !rsp_grid_last)

   // grid end is also a row end
   `GRS_ASSERT_IMPLY(a_grid_row, clock, reset, rsp_valid && rsp_grid_last, rsp_row_last)

endmodule

bind grid_rotate_and_diagonal_skew grs_checker u_grs_checker (.*);

`default_nettype wire
